// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: action codes,
// control characters, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Control characters handled by the put action
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0]  BLANK_CHAR = 8'h20;
  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  // Field widths
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int POS_W    = 11;
  localparam int ATTR_W   = 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_load;    // latch input item, issue cell read
    logic exec;       // apply action to cursor and buffer
    logic ptr_clr;    // restart sweep pointer
    logic ptr_inc;    // advance sweep pointer
    logic rd_scroll;  // read the cell one row below the pointer
    logic wr_copy;    // write read-back cell at the pointer
    logic wr_blank;   // write blank cell with current attribute
    logic wr_init;    // write power-on cell
    logic out_load;   // load the result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    action_t act;
    logic    need_scroll;
    logic    copy_last;
    logic    fill_last;
    logic    out_free;
  } status_t;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller FSM: sequences item intake, execution, buffer sweeps (power-on
// fill, clear, scroll) and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tcw_pkg::status_t  sts,
  output tcw_pkg::cmd_t     cmd
);

  tcw_pkg::state_t state_r;
  tcw_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        cmd.wr_init = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.fill_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec = 1'b1;
          unique case (sts.act)
            tcw_pkg::ACT_PUT: begin
              if (sts.need_scroll) begin
                cmd.ptr_clr = 1'b1;
                state_nxt   = tcw_pkg::ST_SCR_RD;
              end else begin
                cmd.out_load = 1'b1;
                state_nxt    = tcw_pkg::ST_IDLE;
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              cmd.ptr_clr = 1'b1;
              state_nxt   = tcw_pkg::ST_FILL;
            end
            default: begin
              cmd.out_load = 1'b1;
              state_nxt    = tcw_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tcw_pkg::ST_SCR_RD: begin
        cmd.rd_scroll = 1'b1;
        state_nxt     = tcw_pkg::ST_SCR_WR;
      end
      tcw_pkg::ST_SCR_WR: begin
        cmd.wr_copy = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_nxt   = sts.copy_last ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCR_RD;
      end
      tcw_pkg::ST_FILL: begin
        cmd.wr_blank = 1'b1;
        cmd.ptr_inc  = 1'b1;
        if (sts.fill_last) begin
          state_nxt = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell buffer memory, cursor, attribute register, sweep pointer and the
// result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::status_t              sts,
  input  tcw_pkg::action_t              in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]   in_cell_index,
  input  logic                          cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell_data,
  output logic [tcw_pkg::POS_W-1:0]     out_cursor_pos
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > tcw_pkg::INDEX_W) ? AW : tcw_pkg::INDEX_W;

  // Cell buffer
  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

  tcw_pkg::action_t            act_r;
  logic [tcw_pkg::CHAR_W-1:0]  char_r;
  logic                        idx_ok_r;
  logic [CW-1:0]               col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic [CNTW-1:0]             ptr_r, ptr_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic [tcw_pkg::CELL_W-1:0]  rd_data_r;
  logic                        out_valid_r;
  logic [tcw_pkg::CELL_W-1:0]  out_data_r;
  logic [tcw_pkg::POS_W-1:0]   out_pos_r;

  logic                        in_idx_ok;
  logic [CW:0]                 col_ext, col_t, tab_sum;
  logic [RW:0]                 row_t, row_f;
  logic                        printable, wrap, need_scroll;
  logic [CW-1:0]               put_col;
  logic [RW-1:0]               put_row;
  logic [AW-1:0]               cur_addr, rd_addr, wr_addr;
  logic                        rd_en, wr_en;
  logic [tcw_pkg::CELL_W-1:0]  wr_data;
  logic [PW-1:0]               pos_full;

  assign in_idx_ok = (PW + 1)'(in_cell_index) < (PW + 1)'(CELLS);

  // Put-character cursor motion
  assign col_ext = {1'b0, col_r};
  assign tab_sum = col_ext + (CW + 1)'(4);
  always_comb begin
    col_t     = col_ext;
    row_t     = {1'b0, row_r};
    printable = 1'b0;
    unique case (char_r)
      tcw_pkg::CH_LF: begin
        col_t = '0;
        row_t = {1'b0, row_r} + (RW + 1)'(1);
      end
      tcw_pkg::CH_CR: begin
        col_t = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_t = {tab_sum[CW:2], 2'b00};
      end
      tcw_pkg::CH_BS: begin
        if (col_r != '0) begin
          col_t = col_ext - (CW + 1)'(1);
        end
      end
      default: begin
        col_t     = col_ext + (CW + 1)'(1);
        printable = 1'b1;
      end
    endcase
  end

  assign wrap        = col_t >= (CW + 1)'(COLUMNS);
  assign row_f       = wrap ? row_t + (RW + 1)'(1) : row_t;
  assign need_scroll = row_f >= (RW + 1)'(ROWS);
  assign put_col     = wrap ? '0 : col_t[CW-1:0];
  assign put_row     = need_scroll ? RW'(ROWS - 1) : row_f[RW-1:0];

  // Cursor next value
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.exec) begin
      unique case (act_r)
        tcw_pkg::ACT_PUT: begin
          col_nxt = put_col;
          row_nxt = put_row;
        end
        tcw_pkg::ACT_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
          col_nxt = col_r;
          row_nxt = row_r;
        end
      endcase
    end
  end

  // Sweep pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNTW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ptr_r <= ptr_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latched input item
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      act_r    <= in_action;
      char_r   <= in_char_code;
      idx_ok_r <= in_idx_ok;
    end
  end

  // Memory address and data selection
  assign cur_addr = AW'(AW'(row_r) * AW'(COLUMNS)) + AW'(col_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(ptr_r) + AW'(COLUMNS);
    if (cmd.in_load) begin
      rd_en   = in_idx_ok;
      rd_addr = AW'(in_cell_index);
    end else if (cmd.rd_scroll) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(ptr_r);
    wr_data = tcw_pkg::RESET_CELL;
    if (cmd.exec && act_r == tcw_pkg::ACT_PUT && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = {attr_r, char_r};
    end else if (cmd.wr_copy) begin
      wr_en   = 1'b1;
      wr_data = rd_data_r;
    end else if (cmd.wr_blank) begin
      wr_en   = 1'b1;
      wr_data = {attr_r, tcw_pkg::BLANK_CHAR};
    end else if (cmd.wr_init) begin
      wr_en   = 1'b1;
    end
  end

  // Cell buffer ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register
  assign pos_full = PW'(PW'(row_nxt) * PW'(COLUMNS)) + PW'(col_nxt);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (act_r == tcw_pkg::ACT_READ && idx_ok_r) ? rd_data_r : '0;
      out_pos_r  <= pos_full[tcw_pkg::POS_W-1:0];
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_cursor_pos = out_pos_r;

  // Status
  assign sts.act         = act_r;
  assign sts.need_scroll = need_scroll;
  assign sts.copy_last   = ptr_r == CNTW'(CELLS - COLUMNS - 1);
  assign sts.fill_last   = ptr_r == CNTW'(CELLS - 1);
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: text buffer of attribute/character cells and a
// cursor, with control-code handling, wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  in       slave      in_tvalid/tready    action, char_code, cell_index
//  out      master     out_tvalid/tready   cell_data, cursor_pos
//  cfg      write      cfg_wr_en           text_attribute
//
// Put (no scroll), read and idle actions pass through intake, then execute.
// Clear adds one buffer write per cell, then the result step. Scroll adds
// a read and a write for each moved cell on the single-port-pair cell
// memory, then one row blank and the result step.
// After reset the buffer is filled with in_tready low.
// A result waiting on out_tready holds back the execute and result steps.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [1:0] action, [9:2] char_code, [20:10] cell_index, [23:21] zero
  input  logic [23:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [15:0] cell_data, [26:16] cursor_pos, [31:27] zero
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t sts;

  logic [tcw_pkg::CELL_W-1:0] cell_data;
  logic [tcw_pkg::POS_W-1:0]  cursor_pos;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (tcw_pkg::action_t'(in_tdata[1:0])),
    .in_char_code   (in_tdata[9:2]),
    .in_cell_index  (in_tdata[20:10]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_cell_data  (cell_data),
    .out_cursor_pos (cursor_pos)
  );

  assign out_tdata = {5'd0, cursor_pos, cell_data};

  // One item in flight: intake closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // Cursor stays inside the buffer
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CELLS > 2048) || (32'(out_tdata[26:16]) < CELLS))
    else $error("cursor position outside the buffer");

  // Buffer fill after reset blocks intake
  a_init_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during power-on fill");

endmodule
